// ===== rtl/dam_pkg.sv =====
package dam_pkg;

   localparam int MEM_WORDS = 1000;
   localparam int MEM_AW    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
   localparam int WORD_W    = 18;
   localparam int MAG_W     = 17;
   localparam int DATA_W    = 32;
   localparam int PC_W      = 10;
   localparam int CMD_W     = 2;
   localparam int ERR_W     = 4;
   localparam int OPC_W     = 7;
   localparam int WORD_MAX  = 99999;
   localparam int DEC_BASE  = 1000;
   // floor(2^20 / 1000); the quotient estimate is exact or one low
   localparam int DEC_SCALE = 1048;
   localparam int DEC_SHIFT = 20;
   localparam int DEC_PW    = 28;
   localparam int DIV_CNT_W = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD  = 2'd0,
      CMD_START = 2'd1,
      CMD_STEP  = 2'd2,
      CMD_PEEK  = 2'd3
   } cmd_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE      = 4'd0,
      ERR_PC        = 4'd1,
      ERR_INPUT     = 4'd2,
      ERR_DIV0      = 4'd3,
      ERR_MOD0      = 4'd4,
      ERR_NEG_EXP   = 4'd5,
      ERR_POW_OVF   = 4'd6,
      ERR_OPCODE    = 4'd7,
      ERR_ACC_OVF   = 4'd8,
      ERR_LOAD_WORD = 4'd9,
      ERR_MEM_FULL  = 4'd10
   } err_type;

   typedef enum logic [3:0] {
      OPC_READ, OPC_WRITE, OPC_NEWLINE, OPC_LOADA, OPC_STORE, OPC_ADD, OPC_SUB,
      OPC_DIV, OPC_MUL, OPC_MOD, OPC_POW, OPC_BR, OPC_BRNEG, OPC_BRZERO,
      OPC_HALT, OPC_BAD
   } op_type;

   localparam logic [OPC_W-1:0] OP_READ    = 7'd10;
   localparam logic [OPC_W-1:0] OP_WRITE   = 7'd11;
   localparam logic [OPC_W-1:0] OP_NEWLINE = 7'd12;
   localparam logic [OPC_W-1:0] OP_LOADA   = 7'd20;
   localparam logic [OPC_W-1:0] OP_STORE   = 7'd21;
   localparam logic [OPC_W-1:0] OP_ADD     = 7'd30;
   localparam logic [OPC_W-1:0] OP_SUB     = 7'd31;
   localparam logic [OPC_W-1:0] OP_DIV     = 7'd32;
   localparam logic [OPC_W-1:0] OP_MUL     = 7'd33;
   localparam logic [OPC_W-1:0] OP_MOD     = 7'd34;
   localparam logic [OPC_W-1:0] OP_POW     = 7'd35;
   localparam logic [OPC_W-1:0] OP_BR      = 7'd40;
   localparam logic [OPC_W-1:0] OP_BRNEG   = 7'd41;
   localparam logic [OPC_W-1:0] OP_BRZERO  = 7'd42;
   localparam logic [OPC_W-1:0] OP_HALT    = 7'd43;

   typedef struct packed {
      logic    accept;
      logic    clr_wr;
      logic    load_wr;
      logic    start;
      logic    stop;
      logic    set_err;
      err_type err;
      logic    set_load_done;
      logic    peek_rd;
      logic    peek_latch;
      logic    fetch_rd;
      logic    latch_ir;
      logic    dec_q;
      logic    dec_r;
      logic    opnd_rd;
      logic    latch_m;
      logic    set_input_used;
      logic    mem_wr_data;
      logic    mem_wr_acc;
      logic    set_out;
      logic    set_newline;
      logic    acc_ld_m;
      logic    acc_ld_sum;
      logic    acc_ld_prod;
      logic    acc_ld_div;
      logic    acc_one;
      logic    acc_pm1;
      logic    mul_go;
      logic    pow_init;
      logic    pow_mul;
      logic    pow_step;
      logic    div_init;
      logic    div_step;
      logic    pc_jump;
      logic    pc_adv;
      logic    rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      cmd_type cmd_code;
      op_type  op;
      logic    running;
      logic    halted;
      logic    load_sentinel;
      logic    load_full;
      logic    data_oob;
      logic    addr_oob;
      logic    pc_oob;
      logic    opnd_oob;
      logic    m_zero;
      logic    m_neg;
      logic    acc_neg;
      logic    acc_zero;
      logic    acc_one;
      logic    acc_mone;
      logic    addsub_ovf;
      logic    prod_ovf;
      logic    div_last;
      logic    pow_last;
      logic    clr_last;
      logic    rsp_free;
   } dp_stat_type;

   function automatic op_type decode_op(input logic [OPC_W-1:0] code, input logic neg);
      op_type op;
      op = OPC_BAD;
      if (!neg) begin
         unique case (code)
            OP_READ:    op = OPC_READ;
            OP_WRITE:   op = OPC_WRITE;
            OP_NEWLINE: op = OPC_NEWLINE;
            OP_LOADA:   op = OPC_LOADA;
            OP_STORE:   op = OPC_STORE;
            OP_ADD:     op = OPC_ADD;
            OP_SUB:     op = OPC_SUB;
            OP_DIV:     op = OPC_DIV;
            OP_MUL:     op = OPC_MUL;
            OP_MOD:     op = OPC_MOD;
            OP_POW:     op = OPC_POW;
            OP_BR:      op = OPC_BR;
            OP_BRNEG:   op = OPC_BRNEG;
            OP_BRZERO:  op = OPC_BRZERO;
            OP_HALT:    op = OPC_HALT;
            default:    op = OPC_BAD;
         endcase
      end
      return op;
   endfunction

endpackage

// ===== rtl/dam_ram.sv =====
module dam_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 1000
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== rtl/dam_ctrl.sv =====
module dam_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  dam_pkg::dp_stat_type stat,
   output dam_pkg::dp_cmd_type  cmd
);
   import dam_pkg::*;

   typedef enum logic [16:0] {
      S_CLEAR      = 17'h00001,
      S_IDLE       = 17'h00002,
      S_DISPATCH   = 17'h00004,
      S_PEEK_WAIT  = 17'h00008,
      S_FETCH      = 17'h00010,
      S_FETCH_WAIT = 17'h00020,
      S_DEC1       = 17'h00040,
      S_DEC2       = 17'h00080,
      S_OPND       = 17'h00100,
      S_OPND_WAIT  = 17'h00200,
      S_EXEC       = 17'h00400,
      S_MUL_CHK    = 17'h00800,
      S_DIV_RUN    = 17'h01000,
      S_DIV_FIN    = 17'h02000,
      S_POW_MUL    = 17'h04000,
      S_POW_CHK    = 17'h08000,
      S_DONE       = 17'h10000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd       = '0;
      cmd.err   = ERR_NONE;
      state_in  = state_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_DONE;
            unique case (stat.cmd_code)
               CMD_LOAD: begin
                  if (!stat.running) begin
                     if (stat.load_sentinel) begin
                        cmd.set_load_done = 1'b1;
                     end else if (stat.load_full) begin
                        cmd.set_err = 1'b1;
                        cmd.err     = ERR_MEM_FULL;
                     end else if (stat.data_oob) begin
                        cmd.set_err = 1'b1;
                        cmd.err     = ERR_LOAD_WORD;
                     end else begin
                        cmd.load_wr = 1'b1;
                     end
                  end
               end
               CMD_START: cmd.start = 1'b1;
               CMD_STEP: begin
                  if (stat.running) begin
                     if (stat.pc_oob) begin
                        cmd.set_err = 1'b1;
                        cmd.err     = ERR_PC;
                        cmd.stop    = 1'b1;
                     end else begin
                        state_in = S_FETCH;
                     end
                  end
               end
               CMD_PEEK: begin
                  if (!stat.addr_oob) begin
                     cmd.peek_rd = 1'b1;
                     state_in    = S_PEEK_WAIT;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_PEEK_WAIT: begin
            cmd.peek_latch = 1'b1;
            state_in       = S_DONE;
         end
         S_FETCH: begin
            cmd.fetch_rd = 1'b1;
            state_in     = S_FETCH_WAIT;
         end
         S_FETCH_WAIT: begin
            cmd.latch_ir = 1'b1;
            state_in     = S_DEC1;
         end
         S_DEC1: begin
            cmd.dec_q = 1'b1;
            state_in  = S_DEC2;
         end
         S_DEC2: begin
            cmd.dec_r = 1'b1;
            state_in  = S_OPND;
         end
         S_OPND: begin
            if (stat.opnd_oob) begin
               cmd.set_err = 1'b1;
               cmd.err     = ERR_PC;
               cmd.stop    = 1'b1;
               state_in    = S_DONE;
            end else begin
               cmd.opnd_rd = 1'b1;
               state_in    = S_OPND_WAIT;
            end
         end
         S_OPND_WAIT: begin
            cmd.latch_m = 1'b1;
            state_in    = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_DONE;
            unique case (stat.op)
               OPC_READ: begin
                  cmd.set_input_used = 1'b1;
                  if (stat.data_oob) begin
                     cmd.set_err = 1'b1;
                     cmd.err     = ERR_INPUT;
                     cmd.stop    = 1'b1;
                  end else begin
                     cmd.mem_wr_data = 1'b1;
                     cmd.pc_adv      = 1'b1;
                  end
               end
               OPC_WRITE: begin
                  cmd.set_out = 1'b1;
                  cmd.pc_adv  = 1'b1;
               end
               OPC_NEWLINE: begin
                  cmd.set_newline = 1'b1;
                  cmd.pc_adv      = 1'b1;
               end
               OPC_LOADA: begin
                  cmd.acc_ld_m = 1'b1;
                  cmd.pc_adv   = 1'b1;
               end
               OPC_STORE: begin
                  cmd.mem_wr_acc = 1'b1;
                  cmd.pc_adv     = 1'b1;
               end
               OPC_ADD, OPC_SUB: begin
                  if (stat.addsub_ovf) begin
                     cmd.set_err = 1'b1;
                     cmd.err     = ERR_ACC_OVF;
                     cmd.stop    = 1'b1;
                  end else begin
                     cmd.acc_ld_sum = 1'b1;
                     cmd.pc_adv     = 1'b1;
                  end
               end
               OPC_MUL: begin
                  cmd.mul_go = 1'b1;
                  state_in   = S_MUL_CHK;
               end
               OPC_DIV, OPC_MOD: begin
                  if (stat.m_zero) begin
                     cmd.set_err = 1'b1;
                     cmd.err     = (stat.op == OPC_DIV) ? ERR_DIV0 : ERR_MOD0;
                     cmd.stop    = 1'b1;
                  end else begin
                     cmd.div_init = 1'b1;
                     state_in     = S_DIV_RUN;
                  end
               end
               OPC_POW: begin
                  if (stat.m_neg) begin
                     cmd.set_err = 1'b1;
                     cmd.err     = ERR_NEG_EXP;
                     cmd.stop    = 1'b1;
                  end else if (stat.m_zero) begin
                     cmd.acc_one = 1'b1;
                     cmd.pc_adv  = 1'b1;
                  end else if (stat.acc_zero || stat.acc_one) begin
                     cmd.pc_adv = 1'b1;
                  end else if (stat.acc_mone) begin
                     cmd.acc_pm1 = 1'b1;
                     cmd.pc_adv  = 1'b1;
                  end else begin
                     cmd.pow_init = 1'b1;
                     state_in     = S_POW_MUL;
                  end
               end
               OPC_BR: cmd.pc_jump = 1'b1;
               OPC_BRNEG: begin
                  cmd.pc_jump = stat.acc_neg;
                  cmd.pc_adv  = !stat.acc_neg;
               end
               OPC_BRZERO: begin
                  cmd.pc_jump = stat.acc_zero;
                  cmd.pc_adv  = !stat.acc_zero;
               end
               OPC_HALT: cmd.stop = 1'b1;
               OPC_BAD: begin
                  cmd.set_err = 1'b1;
                  cmd.err     = ERR_OPCODE;
                  cmd.stop    = 1'b1;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_MUL_CHK: begin
            state_in = S_DONE;
            if (stat.prod_ovf) begin
               cmd.set_err = 1'b1;
               cmd.err     = ERR_ACC_OVF;
               cmd.stop    = 1'b1;
            end else begin
               cmd.acc_ld_prod = 1'b1;
               cmd.pc_adv      = 1'b1;
            end
         end
         S_DIV_RUN: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_DIV_FIN;
            end
         end
         S_DIV_FIN: begin
            cmd.acc_ld_div = 1'b1;
            cmd.pc_adv     = 1'b1;
            state_in       = S_DONE;
         end
         S_POW_MUL: begin
            cmd.pow_mul = 1'b1;
            state_in    = S_POW_CHK;
         end
         S_POW_CHK: begin
            if (stat.prod_ovf) begin
               cmd.set_err = 1'b1;
               cmd.err     = ERR_POW_OVF;
               cmd.stop    = 1'b1;
               state_in    = S_DONE;
            end else if (stat.pow_last) begin
               cmd.acc_ld_prod = 1'b1;
               cmd.pc_adv      = 1'b1;
               state_in        = S_DONE;
            end else begin
               cmd.pow_step = 1'b1;
               state_in     = S_POW_MUL;
            end
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// ===== rtl/dam_dp.sv =====
module dam_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  dam_pkg::dp_cmd_type                 cmd,
   output dam_pkg::dp_stat_type                stat,
   input  logic [dam_pkg::CMD_W-1:0]           req_command,
   input  logic signed [dam_pkg::DATA_W-1:0]   req_data,
   input  logic [dam_pkg::PC_W-1:0]            req_address,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_out_valid,
   output logic signed [dam_pkg::WORD_W-1:0]   rsp_out_value,
   output logic                                rsp_newline,
   output logic                                rsp_input_used,
   output logic                                rsp_halted,
   output logic [dam_pkg::ERR_W-1:0]           rsp_error_code,
   output logic                                rsp_load_done,
   output logic signed [dam_pkg::WORD_W-1:0]   rsp_acc_value,
   output logic [dam_pkg::PC_W-1:0]            rsp_pc_value,
   output logic signed [dam_pkg::WORD_W-1:0]   rsp_instr_value
);
   import dam_pkg::*;

   // transaction fields
   cmd_type                    cmd_ff;
   logic signed [DATA_W-1:0]   data_ff;
   logic [PC_W-1:0]            addr_ff;

   // machine state
   logic                       running_ff, stopped_ff;
   logic signed [WORD_W-1:0]   acc_ff, ir_ff, m_ff, p_ff;
   logic [PC_W-1:0]            pc_ff, load_cnt_ff, opnd_ff;
   logic [MEM_AW-1:0]          clr_cnt_ff;

   // decode, multiply, divide, power
   logic [OPC_W-1:0]           q0_ff;
   op_type                     op_ff;
   logic signed [2*WORD_W-1:0] prod_ff;
   logic [MAG_W-1:0]           pow_cnt_ff;
   logic [MAG_W-1:0]           div_rem_ff, div_quo_ff;
   logic [DIV_CNT_W-1:0]       div_cnt_ff;

   // result of the current transaction
   logic                       res_out_valid_ff, res_newline_ff, res_input_used_ff;
   logic                       res_load_done_ff;
   logic signed [WORD_W-1:0]   res_out_value_ff;
   err_type                    res_err_ff;

   logic                       rsp_valid_ff, rsp_out_valid_ff, rsp_newline_ff;
   logic                       rsp_input_used_ff, rsp_halted_ff, rsp_load_done_ff;
   logic signed [WORD_W-1:0]   rsp_out_value_ff, rsp_acc_ff, rsp_ir_ff;
   logic [ERR_W-1:0]           rsp_err_ff;
   logic [PC_W-1:0]            rsp_pc_ff;

   // memory ports
   logic                       ram_wr_en;
   logic [MEM_AW-1:0]          ram_wr_addr, ram_rd_addr;
   logic [WORD_W-1:0]          ram_wr_data, ram_rd_data;

   logic                       ir_neg, acc_neg, m_neg;
   logic [MAG_W-1:0]           ir_mag, acc_mag, m_mag;
   logic [DEC_PW-1:0]          dec_prod;
   logic [MAG_W-1:0]           dec_rem;
   logic signed [WORD_W:0]     sum;
   logic signed [WORD_W-1:0]   mul_a, mul_b;
   logic signed [2*WORD_W-1:0] mul_res;
   logic [MAG_W:0]             div_shift, div_trial;
   logic signed [WORD_W-1:0]   div_result;

   dam_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MEM_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign ram_wr_en = cmd.clr_wr | cmd.load_wr | cmd.mem_wr_data | cmd.mem_wr_acc;

   always_comb begin
      ram_wr_addr = clr_cnt_ff;
      ram_wr_data = '0;
      if (cmd.load_wr) begin
         ram_wr_addr = load_cnt_ff[MEM_AW-1:0];
         ram_wr_data = data_ff[WORD_W-1:0];
      end else if (cmd.mem_wr_data) begin
         ram_wr_addr = opnd_ff[MEM_AW-1:0];
         ram_wr_data = data_ff[WORD_W-1:0];
      end else if (cmd.mem_wr_acc) begin
         ram_wr_addr = opnd_ff[MEM_AW-1:0];
         ram_wr_data = acc_ff;
      end
   end

   always_comb begin
      ram_rd_addr = pc_ff[MEM_AW-1:0];
      if (cmd.peek_rd) begin
         ram_rd_addr = addr_ff[MEM_AW-1:0];
      end else if (cmd.opnd_rd) begin
         ram_rd_addr = opnd_ff[MEM_AW-1:0];
      end
   end

   // magnitudes; stored words never exceed 17 bits of magnitude
   assign ir_neg  = ir_ff[WORD_W-1];
   assign acc_neg = acc_ff[WORD_W-1];
   assign m_neg   = m_ff[WORD_W-1];
   assign ir_mag  = ir_neg  ? MAG_W'(-ir_ff)  : ir_ff[MAG_W-1:0];
   assign acc_mag = acc_neg ? MAG_W'(-acc_ff) : acc_ff[MAG_W-1:0];
   assign m_mag   = m_neg   ? MAG_W'(-m_ff)   : m_ff[MAG_W-1:0];

   // opcode = |word| / 1000 by reciprocal, remainder corrected once
   assign dec_prod = DEC_PW'(ir_mag) * DEC_PW'(DEC_SCALE);
   assign dec_rem  = ir_mag - MAG_W'(q0_ff) * MAG_W'(DEC_BASE);

   assign sum = (op_ff == OPC_SUB) ? (WORD_W+1)'(acc_ff) - (WORD_W+1)'(m_ff)
                                   : (WORD_W+1)'(acc_ff) + (WORD_W+1)'(m_ff);

   assign mul_a   = cmd.pow_mul ? p_ff : acc_ff;
   assign mul_b   = cmd.pow_mul ? acc_ff : m_ff;
   assign mul_res = mul_a * mul_b;

   assign div_shift = {div_rem_ff, div_quo_ff[MAG_W-1]};
   assign div_trial = div_shift - {1'b0, m_mag};

   always_comb begin
      if (op_ff == OPC_DIV) begin
         div_result = (acc_neg ^ m_neg) ? -$signed({1'b0, div_quo_ff})
                                        : $signed({1'b0, div_quo_ff});
      end else begin
         div_result = acc_neg ? -$signed({1'b0, div_rem_ff}) : $signed({1'b0, div_rem_ff});
      end
   end

   always_comb begin
      stat               = '0;
      stat.cmd_code      = cmd_ff;
      stat.op            = op_ff;
      stat.running       = running_ff;
      stat.halted        = stopped_ff;
      stat.load_sentinel = (data_ff == WORD_MAX);
      stat.load_full     = (load_cnt_ff >= PC_W'(MEM_WORDS));
      stat.data_oob      = (data_ff > WORD_MAX) || (data_ff < -WORD_MAX);
      stat.addr_oob      = (addr_ff >= PC_W'(MEM_WORDS));
      stat.pc_oob        = (pc_ff >= PC_W'(MEM_WORDS));
      stat.opnd_oob      = (opnd_ff >= PC_W'(MEM_WORDS));
      stat.m_zero        = (m_ff == '0);
      stat.m_neg         = m_neg;
      stat.acc_neg       = acc_neg;
      stat.acc_zero      = (acc_ff == '0);
      stat.acc_one       = (acc_ff == WORD_W'(1));
      stat.acc_mone      = (acc_ff == -WORD_W'(1));
      stat.addsub_ovf    = (sum > WORD_MAX) || (sum < -WORD_MAX);
      stat.prod_ovf      = (prod_ff > WORD_MAX) || (prod_ff < -WORD_MAX);
      stat.div_last      = (div_cnt_ff == DIV_CNT_W'(MAG_W - 1));
      stat.pow_last      = (pow_cnt_ff == MAG_W'(1));
      stat.clr_last      = (clr_cnt_ff == MEM_AW'(MEM_WORDS - 1));
      stat.rsp_free      = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff   <= 1'b0;
         stopped_ff   <= 1'b0;
         acc_ff       <= '0;
         pc_ff        <= '0;
         ir_ff        <= '0;
         load_cnt_ff  <= '0;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_wr) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
         if (cmd.load_wr) begin
            load_cnt_ff <= load_cnt_ff + 1'b1;
         end
         if (cmd.start) begin
            running_ff <= 1'b1;
            stopped_ff <= 1'b0;
         end else if (cmd.stop) begin
            running_ff <= 1'b0;
            stopped_ff <= 1'b1;
         end
         if (cmd.start) begin
            acc_ff <= '0;
         end else if (cmd.acc_ld_m) begin
            acc_ff <= m_ff;
         end else if (cmd.acc_ld_sum) begin
            acc_ff <= sum[WORD_W-1:0];
         end else if (cmd.acc_ld_prod) begin
            acc_ff <= prod_ff[WORD_W-1:0];
         end else if (cmd.acc_ld_div) begin
            acc_ff <= div_result;
         end else if (cmd.acc_one) begin
            acc_ff <= WORD_W'(1);
         end else if (cmd.acc_pm1) begin
            acc_ff <= m_ff[0] ? -WORD_W'(1) : WORD_W'(1);
         end
         if (cmd.start) begin
            pc_ff <= '0;
         end else if (cmd.pc_jump) begin
            pc_ff <= opnd_ff;
         end else if (cmd.pc_adv) begin
            pc_ff <= pc_ff + 1'b1;
         end
         if (cmd.start) begin
            ir_ff <= '0;
         end else if (cmd.latch_ir) begin
            ir_ff <= ram_rd_data;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cmd_ff            <= cmd_type'(req_command);
         data_ff           <= req_data;
         addr_ff           <= req_address;
         res_out_valid_ff  <= 1'b0;
         res_out_value_ff  <= '0;
         res_newline_ff    <= 1'b0;
         res_input_used_ff <= 1'b0;
         res_load_done_ff  <= 1'b0;
         res_err_ff        <= ERR_NONE;
      end
      if (cmd.set_err) begin
         res_err_ff <= cmd.err;
      end
      if (cmd.set_load_done) begin
         res_load_done_ff <= 1'b1;
      end
      if (cmd.set_input_used) begin
         res_input_used_ff <= 1'b1;
      end
      if (cmd.set_newline) begin
         res_newline_ff <= 1'b1;
      end
      if (cmd.set_out) begin
         res_out_valid_ff <= 1'b1;
         res_out_value_ff <= m_ff;
      end else if (cmd.peek_latch) begin
         res_out_value_ff <= ram_rd_data;
      end
      if (cmd.dec_q) begin
         q0_ff <= dec_prod[DEC_SHIFT +: OPC_W];
      end
      if (cmd.dec_r) begin
         if (dec_rem >= MAG_W'(DEC_BASE)) begin
            op_ff   <= decode_op(q0_ff + 1'b1, ir_neg);
            opnd_ff <= PC_W'(dec_rem - MAG_W'(DEC_BASE));
         end else begin
            op_ff   <= decode_op(q0_ff, ir_neg);
            opnd_ff <= PC_W'(dec_rem);
         end
      end
      if (cmd.latch_m) begin
         m_ff <= ram_rd_data;
      end
      if (cmd.mul_go || cmd.pow_mul) begin
         prod_ff <= mul_res;
      end
      if (cmd.pow_init) begin
         p_ff       <= WORD_W'(1);
         pow_cnt_ff <= m_ff[MAG_W-1:0];
      end else if (cmd.pow_step) begin
         p_ff       <= prod_ff[WORD_W-1:0];
         pow_cnt_ff <= pow_cnt_ff - 1'b1;
      end
      if (cmd.div_init) begin
         div_rem_ff <= '0;
         div_quo_ff <= acc_mag;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + 1'b1;
         if (!div_trial[MAG_W]) begin
            div_rem_ff <= div_trial[MAG_W-1:0];
            div_quo_ff <= {div_quo_ff[MAG_W-2:0], 1'b1};
         end else begin
            div_rem_ff <= div_shift[MAG_W-1:0];
            div_quo_ff <= {div_quo_ff[MAG_W-2:0], 1'b0};
         end
      end
      if (cmd.rsp_load) begin
         rsp_out_valid_ff  <= res_out_valid_ff;
         rsp_out_value_ff  <= res_out_value_ff;
         rsp_newline_ff    <= res_newline_ff;
         rsp_input_used_ff <= res_input_used_ff;
         rsp_halted_ff     <= stopped_ff;
         rsp_err_ff        <= res_err_ff;
         rsp_load_done_ff  <= res_load_done_ff;
         rsp_acc_ff        <= acc_ff;
         rsp_pc_ff         <= pc_ff;
         rsp_ir_ff         <= ir_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_valid   = rsp_out_valid_ff;
   assign rsp_out_value   = rsp_out_value_ff;
   assign rsp_newline     = rsp_newline_ff;
   assign rsp_input_used  = rsp_input_used_ff;
   assign rsp_halted      = rsp_halted_ff;
   assign rsp_error_code  = rsp_err_ff;
   assign rsp_load_done   = rsp_load_done_ff;
   assign rsp_acc_value   = rsp_acc_ff;
   assign rsp_pc_value    = rsp_pc_ff;
   assign rsp_instr_value = rsp_ir_ff;

endmodule

// ===== rtl/decimal_accumulator_machine.sv =====
// Decimal accumulator machine: 1000 signed words (+/-99999), one accumulator. Each request
// transaction (load word, start, execute one instruction, peek) returns exactly one response
// transaction carrying the accumulator, program counter and instruction register after it.
// After reset the word memory is cleared one word per cycle, and req_ready stays low until
// the clear is done. An ordinary instruction passes through the two registered memory reads
// (fetch, operand) and the opcode split. Divide and modulo add the bit-serial 17-bit divider;
// power repeats a multiply on the shared 18x18 multiplier, at most 17 multiplies before
// the result leaves range. One transaction is in flight at a time; a finished response waits
// in the output register while the next request is accepted.
module decimal_accumulator_machine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [dam_pkg::CMD_W-1:0]           req_command,
   input  logic signed [dam_pkg::DATA_W-1:0]   req_data,
   input  logic [dam_pkg::PC_W-1:0]            req_address,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_out_valid,
   output logic signed [dam_pkg::WORD_W-1:0]   rsp_out_value,
   output logic                                rsp_newline,
   output logic                                rsp_input_used,
   output logic                                rsp_halted,
   output logic [dam_pkg::ERR_W-1:0]           rsp_error_code,
   output logic                                rsp_load_done,
   output logic signed [dam_pkg::WORD_W-1:0]   rsp_acc_value,
   output logic [dam_pkg::PC_W-1:0]            rsp_pc_value,
   output logic signed [dam_pkg::WORD_W-1:0]   rsp_instr_value
);
   import dam_pkg::*;

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   dam_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   dam_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (dp_cmd),
      .stat            (dp_stat),
      .req_command     (req_command),
      .req_data        (req_data),
      .req_address     (req_address),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_valid   (rsp_out_valid),
      .rsp_out_value   (rsp_out_value),
      .rsp_newline     (rsp_newline),
      .rsp_input_used  (rsp_input_used),
      .rsp_halted      (rsp_halted),
      .rsp_error_code  (rsp_error_code),
      .rsp_load_done   (rsp_load_done),
      .rsp_acc_value   (rsp_acc_value),
      .rsp_pc_value    (rsp_pc_value),
      .rsp_instr_value (rsp_instr_value)
   );

   a_run_stop_excl: assert property (@(posedge clock) disable iff (reset)
      !(dp_stat.running && dp_stat.halted))
      else $error("machine both running and stopped");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while one is in flight");

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pc_value <= PC_W'(MEM_WORDS))
      else $error("program counter beyond memory");

   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error_code != ERR_NONE) && (rsp_error_code != ERR_MEM_FULL)
         && (rsp_error_code != ERR_LOAD_WORD) |-> rsp_halted)
      else $error("execution error without stop");

endmodule

// ===== dv/tb_decimal_accumulator_machine.sv =====
module tb_decimal_accumulator_machine;
   timeunit 1ns;
   timeprecision 1ps;
   import dam_pkg::*;

   localparam int N_RANDOM = 924;

   typedef struct packed {
      logic                     out_valid;
      logic signed [WORD_W-1:0] out_value;
      logic                     newline;
      logic                     input_used;
      logic                     halted;
      logic [ERR_W-1:0]         error_code;
      logic                     load_done;
      logic signed [WORD_W-1:0] acc_value;
      logic [PC_W-1:0]          pc_value;
      logic signed [WORD_W-1:0] instr_value;
   } dam_rsp_type;

   // machine predictor plus queue of expected responses
   class dam_scoreboard;
      longint      mem_word[MEM_WORDS];
      longint      acc;
      int          pc;
      longint      ir;
      int          n_loaded;
      bit          running;
      bit          stopped;
      dam_rsp_type pending[$];
      int          n_err;

      function new();
         foreach (mem_word[i]) mem_word[i] = 0;
         acc = 0; pc = 0; ir = 0; n_loaded = 0; running = 0; stopped = 0; n_err = 0;
      endfunction

      function bit in_range(longint v);
         return v >= -WORD_MAX && v <= WORD_MAX;
      endfunction

      function err_type run_instr(longint din, ref dam_rsp_type r);
         longint opc, opnd, m, res, p;
         if (pc >= MEM_WORDS) return ERR_PC;
         ir = mem_word[pc];
         opc = ir / DEC_BASE;
         opnd = ir % DEC_BASE;
         if (opnd < 0) opnd = -opnd;
         if (opnd >= MEM_WORDS) return ERR_PC;
         m = mem_word[opnd];
         case (opc)
            OP_READ: begin
               r.input_used = 1;
               if (!in_range(din)) return ERR_INPUT;
               mem_word[opnd] = din;
            end
            OP_WRITE: begin r.out_valid = 1; r.out_value = WORD_W'(m); end
            OP_NEWLINE: r.newline = 1;
            OP_LOADA: acc = m;
            OP_STORE: mem_word[opnd] = acc;
            OP_ADD, OP_SUB, OP_MUL: begin
               res = (opc == OP_ADD) ? acc + m : (opc == OP_SUB) ? acc - m : acc * m;
               if (!in_range(res)) return ERR_ACC_OVF;
               acc = res;
            end
            OP_DIV: begin
               if (m == 0) return ERR_DIV0;
               acc = acc / m;
            end
            OP_MOD: begin
               if (m == 0) return ERR_MOD0;
               acc = acc % m;
            end
            OP_POW: begin
               if (m < 0) return ERR_NEG_EXP;
               if (m == 0) acc = 1;
               else if (acc == -1) acc = m[0] ? -1 : 1;
               else if (acc != 0 && acc != 1) begin
                  p = 1;
                  for (longint i = 0; i < m; i++) begin
                     p = p * acc;
                     if (!in_range(p)) return ERR_POW_OVF;
                  end
                  acc = p;
               end
            end
            OP_BR: begin pc = int'(opnd); return ERR_NONE; end
            OP_BRNEG: if (acc < 0) begin pc = int'(opnd); return ERR_NONE; end
            OP_BRZERO: if (acc == 0) begin pc = int'(opnd); return ERR_NONE; end
            OP_HALT: begin running = 0; stopped = 1; return ERR_NONE; end
            default: return ERR_OPCODE;
         endcase
         pc = pc + 1;
         return ERR_NONE;
      endfunction

      function void note_request(cmd_type c, logic signed [DATA_W-1:0] d,
                                 logic [PC_W-1:0] a);
         dam_rsp_type r;
         err_type     e;
         longint      din;
         r = '0;
         e = ERR_NONE;
         din = d;
         case (c)
            CMD_LOAD: if (!running) begin
               if (din == WORD_MAX) r.load_done = 1;
               else if (n_loaded >= MEM_WORDS) e = ERR_MEM_FULL;
               else if (!in_range(din)) e = ERR_LOAD_WORD;
               else begin mem_word[n_loaded] = din; n_loaded++; end
            end
            CMD_START: begin
               acc = 0; pc = 0; ir = 0; stopped = 0; running = 1;
            end
            CMD_STEP: if (running) begin
               e = run_instr(din, r);
               if (e != ERR_NONE) begin running = 0; stopped = 1; end
            end
            default: if (a < MEM_WORDS) r.out_value = WORD_W'(mem_word[a]);
         endcase
         r.halted = stopped;
         r.error_code = e;
         r.acc_value = WORD_W'(acc);
         r.pc_value = PC_W'(pc);
         r.instr_value = WORD_W'(ir);
         pending.push_back(r);
      endfunction

      function void check_response(dam_rsp_type got);
         dam_rsp_type x;
         if (pending.size() == 0) begin
            n_err++;
            if (n_err <= 10) $display("unexpected response transaction at %0t", $realtime);
            return;
         end
         x = pending.pop_front();
         if (got !== x) begin
            n_err++;
            if (n_err <= 10)
               $display("response diff at %0t: exp %p got %p", $realtime, x, got);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_ready;
   logic [CMD_W-1:0] req_command = '0;
   logic signed [DATA_W-1:0] req_data = '0;
   logic [PC_W-1:0] req_address = '0;
   logic rsp_valid, rsp_ready = 0;
   dam_rsp_type rsp_seen;
   logic rsp_out_valid, rsp_newline, rsp_input_used, rsp_halted, rsp_load_done;
   logic signed [WORD_W-1:0] rsp_out_value, rsp_acc_value, rsp_instr_value;
   logic [ERR_W-1:0] rsp_error_code;
   logic [PC_W-1:0] rsp_pc_value;

   dam_scoreboard sb = new();
   int cycle_cnt = 0;
   int burst_left = 0;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   decimal_accumulator_machine u_top (.*);

   // response side: stall pattern alternates between busy phases and free running
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > 3000000) begin
         $display("decimal_accumulator_machine: mismatch");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_seen.out_valid = rsp_out_valid;
         rsp_seen.out_value = rsp_out_value;
         rsp_seen.newline = rsp_newline;
         rsp_seen.input_used = rsp_input_used;
         rsp_seen.halted = rsp_halted;
         rsp_seen.error_code = rsp_error_code;
         rsp_seen.load_done = rsp_load_done;
         rsp_seen.acc_value = rsp_acc_value;
         rsp_seen.pc_value = rsp_pc_value;
         rsp_seen.instr_value = rsp_instr_value;
         sb.check_response(rsp_seen);
      end
   end

   always @(negedge clock) begin
      if (cycle_cnt[9:8] == 2'b11) rsp_ready <= 1;
      else if (cycle_cnt[9]) rsp_ready <= ($urandom_range(3) != 0);
      else rsp_ready <= ($urandom_range(1) == 0);
   end

   // valid stays high across a burst; it drops only for a gap or a drain
   task automatic send_req(cmd_type c, logic signed [DATA_W-1:0] d, logic [PC_W-1:0] a);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(12, 1);
         gap = $urandom_range(6);
         if (gap != 0) begin
            req_valid <= 0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1;
      req_command <= c;
      req_data <= d;
      req_address <= a;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(c, d, a);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(negedge clock);
      while (sb.pending.size() != 0) @(negedge clock);
   endtask

   function automatic int enc_instr(int opc, int opnd);
      return opc * DEC_BASE + opnd;
   endfunction

   function automatic int rnd_word();
      case ($urandom_range(5))
         0: return $urandom_range(9) - 4;
         1: return $urandom_range(2 * WORD_MAX) - WORD_MAX;
         2: return $urandom_range(40) - 20;
         3: return $urandom_range(600) - 300;
         4: return $urandom_range(1) ? WORD_MAX - 1 : -WORD_MAX;
         default: return $urandom_range(20000) - 10000;
      endcase
   endfunction

   // valid opcodes; data operands point into the small data region at 900..919, branches into the program
   function automatic int rnd_instr(int prog_len);
      int ops[15] = '{OP_READ, OP_WRITE, OP_NEWLINE, OP_LOADA, OP_STORE, OP_ADD, OP_SUB,
                      OP_DIV, OP_MUL, OP_MOD, OP_POW, OP_BR, OP_BRNEG, OP_BRZERO, OP_HALT};
      int k;
      k = ops[$urandom_range(14)];
      if (k == OP_BR || k == OP_BRNEG || k == OP_BRZERO)
         return enc_instr(k, $urandom_range(prog_len - 1));
      if (k == OP_HALT && $urandom_range(3) != 0) k = OP_ADD;
      return enc_instr(k, 900 + $urandom_range(19));
   endfunction

   task automatic load_words(ref int words[$]);
      foreach (words[i]) send_req(CMD_LOAD, words[i], PC_W'($urandom));
      send_req(CMD_LOAD, WORD_MAX, PC_W'($urandom));
   endtask

   int prog[$];
   int sent;

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: load edge cases, then a short program
      send_req(CMD_STEP, 0, 0);
      send_req(CMD_LOAD, 32'sh7fffffff, 10'h3ff);
      send_req(CMD_LOAD, 32'sh80000000, 0);
      send_req(CMD_LOAD, WORD_MAX + 1, 0);
      send_req(CMD_LOAD, enc_instr(OP_READ, 5), 0);
      send_req(CMD_LOAD, enc_instr(OP_POW, 5), 0);
      send_req(CMD_LOAD, enc_instr(OP_BR, 3), 0);
      send_req(CMD_LOAD, WORD_MAX, 0);
      send_req(CMD_PEEK, 0, 10'h3ff);
      send_req(CMD_PEEK, 0, 2);
      send_req(CMD_START, 0, 0);
      send_req(CMD_LOAD, 7, 0);
      send_req(CMD_STEP, 32'sh7fffffff, 0);
      send_req(CMD_START, 0, 0);
      send_req(CMD_STEP, 17, 0);
      send_req(CMD_STEP, -3, 0);
      send_req(CMD_STEP, 0, 0);
      send_req(CMD_STEP, 0, 0);
      send_req(CMD_PEEK, 0, 5);
      drain();

      // random program behind the directed words, data region at 900..919
      for (int i = 3; i < 900; i++) prog.push_back(rnd_instr(900));
      for (int i = 900; i < 920; i++) prog.push_back(rnd_word());
      load_words(prog);
      drain();

      sent = 0;
      while (sent < N_RANDOM) begin
         send_req(CMD_START, 0, 0);
         sent++;
         for (int i = 0; i < 20 && sent < N_RANDOM; i++) begin
            case ($urandom_range(9))
               0: send_req(CMD_PEEK, 0, PC_W'($urandom));
               1: send_req(CMD_LOAD, $urandom, PC_W'($urandom));
               2: send_req(CMD_START, 0, 0);
               default: send_req(CMD_STEP, rnd_word(), PC_W'($urandom));
            endcase
            sent++;
         end
         if ($urandom_range(7) == 0) drain();
      end
      drain();

      // bad input on the read at address 0 stops the machine, then fill to the top
      send_req(CMD_START, 0, 0);
      send_req(CMD_STEP, 32'sh7fffffff, 0);
      while (sb.n_loaded < MEM_WORDS) send_req(CMD_LOAD, rnd_word(), 0);
      send_req(CMD_LOAD, 1, 0);
      send_req(CMD_LOAD, WORD_MAX, 0);
      send_req(CMD_PEEK, 0, MEM_WORDS - 1);
      send_req(CMD_START, 0, 0);
      send_req(CMD_STEP, 0, 0);
      send_req(CMD_STEP, 0, 0);
      send_req(CMD_PEEK, 0, 5);
      drain();

      repeat (200) @(negedge clock);
      if (sb.n_err == 0 && sb.pending.size() == 0)
         $display("decimal_accumulator_machine: match");
      else
         $display("decimal_accumulator_machine: mismatch");
      $finish;
   end
endmodule

// ===== decimal_accumulator_machine.f =====
rtl/dam_pkg.sv
rtl/dam_ram.sv
rtl/dam_ctrl.sv
rtl/dam_dp.sv
rtl/decimal_accumulator_machine.sv
dv/tb_decimal_accumulator_machine.sv
